// ===== hw/rtl/rhh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robin Hood hash table package
// Shared constants, operation and status codes, the job type and the FNV-1a
// step function.
// ----------------------------------------------------------------------------
package rhh_pkg;

  // Default configuration of the table.
  localparam int TABLE_SLOTS_DEF = 256;
  localparam int KEY_BYTES_DEF   = 8;
  localparam int VALUE_BITS_DEF  = 32;

  // Port widths.
  localparam int IN_W    = 104;
  localparam int OUT_W   = 112;
  localparam int CFG_W   = 9;
  localparam int COUNT_W = 9;
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 9'd192;

  // FNV-1a constants. The prime is 2^40 + 0x1b3.
  localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME_LO = 64'h00000000000001b3;

  // Operation codes.
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_PUT    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_UPDATED  = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;
  localparam logic [2:0] ST_REMOVED  = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  // A classified and hashed operation handed from front to back.
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [3:0]  len;
    logic [31:0] value;
    logic [63:0] hash;
  } rhh_job_t;

  // One FNV-1a byte step: xor the byte in, then multiply by the prime.
  function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x * FNV_PRIME_LO);
  endfunction

endpackage

// ===== hw/rtl/robin_hood_hash_table.sv =====
`timescale 1ns / 1ps
// Operation flow: the front hashes the key one byte per cycle (FNV-1a), then the back reads
// each searched slot through the registered memory read before it compares that slot.
// Insert and removal then walk further slots after the search, with the same registered read.
// The front can take and hash the next operation while the back still works on the last one,
// since jobs pass between them through a two-entry queue.
// Reset empties the table at once (used flags in flip-flops), sets max_entries to 192.
// ----------------------------------------------------------------------------
// Robin Hood hash table
// Open-addressing key/value table with FNV-1a hashing, Robin Hood insert and
// backward-shift removal.
// ----------------------------------------------------------------------------
module robin_hood_hash_table #(
  parameter int TABLE_SLOTS = rhh_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = rhh_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BITS  = rhh_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // func[1:0], key_bytes[65:2], key_len[69:66], value_in[101:70], zero pad
  input  logic [rhh_pkg::IN_W-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // status[2:0], value_out[34:3], hash_out[98:35], entry_count[107:99], zero pad
  output logic [rhh_pkg::OUT_W-1:0] m_axis_tdata_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rhh_pkg::CFG_W-1:0] cfg_data_i
);

  logic                      job_valid, job_pop;
  rhh_pkg::rhh_job_t         job;
  logic [rhh_pkg::CFG_W-1:0] max_entries_q;

  // Limit register, written on each configuration transfer.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= rhh_pkg::MAX_ENTRIES_RST;
    end else if (cfg_valid_i) begin
      max_entries_q <= cfg_data_i;
    end
  end

  rhh_front #(.KEY_BYTES(KEY_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  rhh_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job),
    .job_pop_o     (job_pop),
    .max_entries_i (max_entries_q),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_data_o    (m_axis_tdata_o)
  );

endmodule

// ===== hw/rtl/rhh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rhh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/rhh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robin Hood hash table front end
// Accepts operations, trims the key to its length, hashes it one byte per
// cycle and places the job in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rhh_front #(
  parameter int KEY_BYTES = rhh_pkg::KEY_BYTES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [rhh_pkg::IN_W-1:0] in_data_i,
  output logic                     job_valid_o,
  output rhh_pkg::rhh_job_t        job_o,
  input  logic                     job_pop_i
);

  localparam logic [3:0] LEN_MAX = 4'(KEY_BYTES);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]        st_q, st_d;
  logic [2:0]        byte_q, byte_d;
  rhh_pkg::rhh_job_t job_q, job_d;
  rhh_pkg::rhh_job_t q_mem_q [2];
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q;
  logic              push, pop;
  logic [3:0]        len_sat;
  logic [63:0]       key_mask;

  assign in_ready_o  = (st_q == F_IDLE);
  assign push        = (st_q == F_PUSH) && (cnt_q != 2'd2);
  assign pop         = job_pop_i && (cnt_q != 2'd0);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem_q[rd_q];

  // Saturate the length and mask off key bytes beyond it.
  always_comb begin
    len_sat = (in_data_i[69:66] > LEN_MAX) ? LEN_MAX : in_data_i[69:66];
    for (int b = 0; b < 8; b++) begin
      key_mask[8*b +: 8] = (4'(b) < len_sat) ? 8'hff : 8'h00;
    end
  end

  // Accept, hash and hand over.
  always_comb begin
    st_d   = st_q;
    byte_d = byte_q;
    job_d  = job_q;
    unique case (st_q)
      F_IDLE: begin
        if (in_valid_i) begin
          job_d.func  = in_data_i[1:0];
          job_d.key   = in_data_i[65:2] & key_mask;
          job_d.len   = len_sat;
          job_d.value = in_data_i[101:70];
          job_d.hash  = (in_data_i[1:0] == rhh_pkg::FUNC_CLEAR) ? 64'd0 : rhh_pkg::FNV_BASIS;
          byte_d      = 3'd0;
          st_d = (in_data_i[1:0] == rhh_pkg::FUNC_CLEAR || len_sat == 4'd0) ? F_PUSH : F_HASH;
        end
      end
      F_HASH: begin
        job_d.hash = rhh_pkg::fnv_step(job_q.hash, job_q.key[8*byte_q +: 8]);
        byte_d     = byte_q + 3'd1;
        if ({1'b0, byte_q} + 4'd1 == job_q.len) begin
          st_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push) begin
          st_d = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_IDLE;
      byte_q <= 3'd0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      st_q   <= st_d;
      byte_q <= byte_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (push) begin
      q_mem_q[wr_q] <= job_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("job queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_i |-> cnt_q != 2'd0)
    else $error("pop from empty job queue");
  a_hash_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == F_HASH |-> {1'b0, byte_q} < job_q.len)
    else $error("hash step beyond key length");
`endif

endmodule

// ===== hw/rtl/rhh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robin Hood hash table back end
// Walks slot memory for lookup, update, Robin Hood insert and backward-shift
// removal, empties the used flags on clear, and holds the result in an output register.
// ----------------------------------------------------------------------------
module rhh_back #(
  parameter int TABLE_SLOTS = rhh_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = rhh_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BITS  = rhh_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  rhh_pkg::rhh_job_t         job_i,
  output logic                      job_pop_o,
  input  logic [rhh_pkg::CFG_W-1:0] max_entries_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rhh_pkg::OUT_W-1:0] out_data_o
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int KW    = 8 * KEY_BYTES;
  localparam int EW    = IDX_W + 4 + KW + VALUE_BITS;
  localparam int K_LO  = VALUE_BITS;
  localparam int L_LO  = VALUE_BITS + KW;
  localparam int P_LO  = VALUE_BITS + KW + 4;
  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(TABLE_SLOTS);

  localparam logic [2:0] B_IDLE    = 3'd0;
  localparam logic [2:0] B_FRD     = 3'd1;
  localparam logic [2:0] B_FCMP    = 3'd2;
  localparam logic [2:0] B_INS_CHK = 3'd3;
  localparam logic [2:0] B_INS_CMP = 3'd4;
  localparam logic [2:0] B_REM_CHK = 3'd5;
  localparam logic [2:0] B_REM_CMP = 3'd6;
  localparam logic [2:0] B_DONE    = 3'd7;

  logic [2:0]             st_q, st_d;
  logic [TABLE_SLOTS-1:0] used_q, used_d;
  logic [CNT_W-1:0]       occ_q, occ_d;
  logic [IDX_W-1:0]       idx_q, idx_d, prev_q, prev_d;
  logic [CNT_W-1:0]       dist_q, dist_d, cnt_q, cnt_d;
  rhh_pkg::rhh_job_t      job_q, job_d;
  logic [KW-1:0]          car_key_q, car_key_d;
  logic [3:0]             car_len_q, car_len_d;
  logic [VALUE_BITS-1:0]  car_val_q, car_val_d;
  logic [2:0]             status_q, status_d;
  logic [31:0]            vout_q, vout_d;
  logic                   out_valid_q;
  logic [rhh_pkg::OUT_W-1:0] out_data_q;
  logic                   out_load;

  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [EW-1:0]          wdata, rdata;
  logic [IDX_W-1:0]       rd_probe;
  logic [3:0]             rd_len;
  logic [KW-1:0]          rd_key;
  logic [VALUE_BITS-1:0]  rd_val;
  logic                   key_match, table_full;

  rhh_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // Fields of the slot just read.
  assign rd_val    = rdata[VALUE_BITS-1:0];
  assign rd_key    = rdata[K_LO +: KW];
  assign rd_len    = rdata[L_LO +: 4];
  assign rd_probe  = rdata[P_LO +: IDX_W];
  assign key_match = (rd_len == job_q.len) && (rd_key == job_q.key[KW-1:0]);
  assign table_full = (17'(occ_q) >= 17'(max_entries_i)) || (occ_q >= SLOTS);
  assign out_load  = (st_q == B_DONE) && (!out_valid_q || out_ready_i);
  assign job_pop_o = (st_q == B_IDLE) && job_valid_i;

  // Probe, insert and shift sequencer.
  always_comb begin
    st_d      = st_q;
    used_d    = used_q;
    occ_d     = occ_q;
    idx_d     = idx_q;
    prev_d    = prev_q;
    dist_d    = dist_q;
    cnt_d     = cnt_q;
    job_d     = job_q;
    car_key_d = car_key_q;
    car_len_d = car_len_q;
    car_val_d = car_val_q;
    status_d  = status_q;
    vout_d    = vout_q;
    we        = 1'b0;
    waddr     = idx_q;
    wdata     = {idx_q, job_q.len, job_q.key[KW-1:0], VALUE_BITS'(job_q.value)};
    unique case (st_q)
      B_IDLE: begin
        if (job_valid_i) begin
          job_d  = job_i;
          vout_d = 32'd0;
          idx_d  = job_i.hash[IDX_W-1:0];
          dist_d = '0;
          cnt_d  = '0;
          if (job_i.func == rhh_pkg::FUNC_CLEAR) begin
            used_d   = '0;
            occ_d    = '0;
            status_d = rhh_pkg::ST_CLEARED;
            st_d     = B_DONE;
          end else begin
            st_d = B_FRD;
          end
        end
      end
      B_FRD, B_FCMP: begin
        // Search; a miss is an empty slot, a richer slot or a full sweep.
        logic miss;
        miss = 1'b0;
        if (st_q == B_FRD) begin
          if (cnt_q == SLOTS || !used_q[idx_q]) begin
            miss = 1'b1;
          end else begin
            st_d = B_FCMP;
          end
        end else if ({1'b0, rd_probe} < dist_q) begin
          miss = 1'b1;
        end else if (key_match) begin
          st_d = B_DONE;
          case (job_q.func)
            rhh_pkg::FUNC_LOOKUP: begin
              status_d = rhh_pkg::ST_HIT;
              vout_d   = 32'(rd_val);
            end
            rhh_pkg::FUNC_PUT: begin
              we       = 1'b1;
              wdata    = {rd_probe, rd_len, rd_key, VALUE_BITS'(job_q.value)};
              status_d = rhh_pkg::ST_UPDATED;
            end
            default: begin
              used_d[idx_q] = 1'b0;
              occ_d    = occ_q - CNT_W'(1);
              status_d = rhh_pkg::ST_REMOVED;
              prev_d   = idx_q;
              idx_d    = idx_q + IDX_W'(1);
              cnt_d    = CNT_W'(1);
              st_d     = B_REM_CHK;
            end
          endcase
        end else begin
          idx_d  = idx_q + IDX_W'(1);
          dist_d = dist_q + CNT_W'(1);
          cnt_d  = cnt_q + CNT_W'(1);
          st_d   = B_FRD;
        end
        if (miss) begin
          st_d     = B_DONE;
          status_d = rhh_pkg::ST_MISS;
          if (job_q.func == rhh_pkg::FUNC_PUT) begin
            if (table_full) begin
              status_d = rhh_pkg::ST_REJECTED;
            end else begin
              car_key_d = job_q.key[KW-1:0];
              car_len_d = job_q.len;
              car_val_d = VALUE_BITS'(job_q.value);
              idx_d     = job_q.hash[IDX_W-1:0];
              dist_d    = '0;
              st_d      = B_INS_CHK;
            end
          end
        end
      end
      B_INS_CHK: begin
        // Drop the carried entry in the first free slot.
        if (!used_q[idx_q]) begin
          we            = 1'b1;
          wdata         = {dist_q[IDX_W-1:0], car_len_q, car_key_q, car_val_q};
          used_d[idx_q] = 1'b1;
          occ_d         = occ_q + CNT_W'(1);
          status_d      = rhh_pkg::ST_INSERTED;
          st_d          = B_DONE;
        end else begin
          st_d = B_INS_CMP;
        end
      end
      B_INS_CMP: begin
        // Take the slot from a richer entry and carry that one on.
        if (dist_q > {1'b0, rd_probe}) begin
          we        = 1'b1;
          wdata     = {dist_q[IDX_W-1:0], car_len_q, car_key_q, car_val_q};
          car_key_d = rd_key;
          car_len_d = rd_len;
          car_val_d = rd_val;
          dist_d    = {1'b0, rd_probe} + CNT_W'(1);
        end else begin
          dist_d = dist_q + CNT_W'(1);
        end
        idx_d = idx_q + IDX_W'(1);
        st_d  = B_INS_CHK;
      end
      B_REM_CHK: begin
        if (cnt_q == SLOTS || !used_q[idx_q]) begin
          st_d = B_DONE;
        end else begin
          st_d = B_REM_CMP;
        end
      end
      B_REM_CMP: begin
        // Shift the displaced entry back by one slot.
        if (rd_probe == '0) begin
          st_d = B_DONE;
        end else begin
          we             = 1'b1;
          waddr          = prev_q;
          wdata          = {rd_probe - IDX_W'(1), rd_len, rd_key, rd_val};
          used_d[prev_q] = 1'b1;
          used_d[idx_q]  = 1'b0;
          prev_d         = idx_q;
          idx_d          = idx_q + IDX_W'(1);
          cnt_d          = cnt_q + CNT_W'(1);
          st_d           = B_REM_CHK;
        end
      end
      B_DONE: begin
        if (out_load) begin
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      used_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      used_q <= used_d;
      occ_q  <= occ_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    prev_q    <= prev_d;
    dist_q    <= dist_d;
    cnt_q     <= cnt_d;
    job_q     <= job_d;
    car_key_q <= car_key_d;
    car_len_q <= car_len_d;
    car_val_q <= car_val_d;
    status_q  <= status_d;
    vout_q    <= vout_d;
    if (out_load) begin
      out_data_q <= {4'd0, rhh_pkg::COUNT_W'(occ_q), job_q.hash, vout_q, status_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_occ_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == B_IDLE |-> $countones(used_q) == int'(occ_q))
    else $error("occupancy does not match used slots");
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= SLOTS)
    else $error("occupancy beyond table size");
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && status_q == rhh_pkg::ST_CLEARED |=> used_q == '0)
    else $error("table not empty after clear");
`endif

endmodule

// ===== tb/robin_hood_hash_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robin Hood hash table testbench
// Drives lookup, put, remove and clear operations into the table and checks
// every result against a cycle-free predictor of the slot array. Covers key
// length corner cases, the insert limit, a completely full table and random
// traffic over a small key pool, under three idling settings, the last with no idling.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_tb;

  localparam int SLOTS      = 256;
  localparam int POOL_SIZE  = 48;
  localparam int IDLE_LIMIT = 40000;
  localparam logic [63:0] FNV_MULT = 64'h00000100000001b3;

  // One result of the table, packed from the highest field down.
  typedef struct packed {
    logic [8:0]  count;
    logic [63:0] hash;
    logic [31:0] value;
    logic [2:0]  status;
  } table_rsp_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid_i;
  logic                         s_axis_tready_o;
  logic [rhh_pkg::IN_W-1:0]     s_axis_tdata_i;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i;
  logic [rhh_pkg::OUT_W-1:0]    m_axis_tdata_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [rhh_pkg::CFG_W-1:0]    cfg_data_i;

  // Shadow copy of the slot array and the register.
  logic        sh_used  [SLOTS];
  logic [7:0]  sh_probe [SLOTS];
  logic [63:0] sh_key   [SLOTS];
  logic [3:0]  sh_len   [SLOTS];
  logic [31:0] sh_value [SLOTS];
  int unsigned sh_count;
  int unsigned sh_limit;

  table_rsp_t  pending_rsp[$];
  int          errors;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [63:0] pool_key [POOL_SIZE];
  logic [3:0]  pool_len [POOL_SIZE];

  robin_hood_hash_table i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // FNV-1a over the first len bytes of the key.
  function automatic logic [63:0] fnv_hash(logic [63:0] key, int unsigned len);
    logic [63:0] h;
    h = rhh_pkg::FNV_BASIS;
    for (int b = 0; b < len; b++) begin
      h = (h ^ {56'd0, key[8*b +: 8]}) * FNV_MULT;
    end
    return h;
  endfunction

  // Probe walk; returns the slot holding the key, or -1.
  function automatic int find_slot(logic [63:0] key, logic [3:0] len, int home);
    int i;
    int probe_dist;
    i = home;
    probe_dist = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (!sh_used[i] || sh_probe[i] < probe_dist) return -1;
      if (sh_len[i] == len && sh_key[i] == key) return i;
      i = (i + 1) % SLOTS;
      probe_dist++;
    end
    return -1;
  endfunction

  // Robin Hood insert of an absent key; swaps with richer slots.
  function automatic void insert_key(logic [63:0] key, logic [3:0] len,
                                     logic [31:0] val, int home);
    int i;
    int probe_dist;
    int tp;
    logic [63:0] tk;
    logic [3:0] tl;
    logic [31:0] tv;
    i = home;
    probe_dist = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (!sh_used[i]) begin
        sh_used[i] = 1'b1;
        sh_probe[i] = probe_dist[7:0];
        sh_key[i] = key;
        sh_len[i] = len;
        sh_value[i] = val;
        return;
      end
      if (probe_dist > sh_probe[i]) begin
        tp = sh_probe[i];
        tk = sh_key[i];
        tl = sh_len[i];
        tv = sh_value[i];
        sh_probe[i] = probe_dist[7:0];
        sh_key[i] = key;
        sh_len[i] = len;
        sh_value[i] = val;
        probe_dist = tp;
        key = tk;
        len = tl;
        val = tv;
      end
      i = (i + 1) % SLOTS;
      probe_dist++;
    end
  endfunction

  // Backward-shift deletion starting at idx.
  function automatic void delete_slot(int idx);
    int prev;
    int i;
    prev = idx;
    i = (idx + 1) % SLOTS;
    sh_used[idx] = 1'b0;
    for (int n = 1; n < SLOTS; n++) begin
      if (!sh_used[i] || sh_probe[i] == 0) break;
      sh_used[prev] = 1'b1;
      sh_probe[prev] = sh_probe[i] - 8'd1;
      sh_key[prev] = sh_key[i];
      sh_len[prev] = sh_len[i];
      sh_value[prev] = sh_value[i];
      sh_used[i] = 1'b0;
      prev = i;
      i = (i + 1) % SLOTS;
    end
  endfunction

  // Applies one operation to the shadow table and returns its result.
  function automatic table_rsp_t apply_op(logic [1:0] func, logic [63:0] key_in,
                                          logic [3:0] len_in, logic [31:0] val);
    table_rsp_t r;
    logic [3:0] len;
    logic [63:0] key;
    int where;
    len = (len_in > 4'd8) ? 4'd8 : len_in;
    key = (len == 0) ? 64'd0 : key_in & ({64{1'b1}} >> (64 - 8 * len));
    r.hash = fnv_hash(key, len);
    r.value = '0;
    where = find_slot(key, len, int'(r.hash[7:0]));
    case (func)
      rhh_pkg::FUNC_LOOKUP: begin
        if (where >= 0) begin
          r.status = rhh_pkg::ST_HIT;
          r.value = sh_value[where];
        end else begin
          r.status = rhh_pkg::ST_MISS;
        end
      end
      rhh_pkg::FUNC_PUT: begin
        if (where >= 0) begin
          sh_value[where] = val;
          r.status = rhh_pkg::ST_UPDATED;
        end else if (sh_count >= sh_limit || sh_count >= SLOTS) begin
          r.status = rhh_pkg::ST_REJECTED;
        end else begin
          insert_key(key, len, val, int'(r.hash[7:0]));
          sh_count++;
          r.status = rhh_pkg::ST_INSERTED;
        end
      end
      rhh_pkg::FUNC_REMOVE: begin
        if (where >= 0) begin
          delete_slot(where);
          if (sh_count > 0) sh_count--;
          r.status = rhh_pkg::ST_REMOVED;
        end else begin
          r.status = rhh_pkg::ST_MISS;
        end
      end
      default: begin
        for (int s = 0; s < SLOTS; s++) sh_used[s] = 1'b0;
        sh_count = 0;
        r.status = rhh_pkg::ST_CLEARED;
        r.hash = '0;
      end
    endcase
    r.count = sh_count[8:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] exp_val);
    $display("%0t: %s mismatch, got %h, expected %h", $realtime, field, got, exp_val);
    errors++;
  endtask

  // Sends one operation; the prediction is made when the transfer happens.
  task automatic send_op(logic [1:0] func, logic [63:0] key, logic [3:0] len,
                         logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {2'd0, val, len, key, func};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_rsp.push_back(apply_op(func, key, len, val));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes max_entries once the table is idle.
  task automatic write_limit(int unsigned limit);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= limit[8:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    sh_limit = limit;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver stalls and result checking.
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    table_rsp_t got;
    table_rsp_t exp_rsp;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[107:0];
      if (pending_rsp.size() == 0) begin
        $display("%0t: result transfer with nothing outstanding", $realtime);
        errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (got.status != exp_rsp.status) report_mismatch("status", got.status, exp_rsp.status);
        if (got.value != exp_rsp.value) report_mismatch("value_out", got.value, exp_rsp.value);
        if (got.hash != exp_rsp.hash) report_mismatch("hash_out", got.hash, exp_rsp.hash);
        if (got.count != exp_rsp.count) report_mismatch("entry_count", got.count, exp_rsp.count);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Key length corners, update, hit, remove, absent remove and clear.
  task automatic test_directed();
    send_op(rhh_pkg::FUNC_LOOKUP, 64'h0, 4'd0, 32'h0);
    send_op(rhh_pkg::FUNC_PUT, 64'hffff_ffff_ffff_ffff, 4'd0, 32'hffff_ffff);
    send_op(rhh_pkg::FUNC_LOOKUP, 64'h1234, 4'd0, 32'h0);
    send_op(rhh_pkg::FUNC_PUT, 64'hffff_ffff_ffff_ffff, 4'd15, 32'h0000_0001);
    send_op(rhh_pkg::FUNC_LOOKUP, 64'hffff_ffff_ffff_ffff, 4'd8, 32'h0);
    send_op(rhh_pkg::FUNC_PUT, 64'hdead_beef_0000_00a5, 4'd1, 32'h8000_0000);
    send_op(rhh_pkg::FUNC_LOOKUP, 64'h0000_0000_0000_00a5, 4'd1, 32'h0);
    send_op(rhh_pkg::FUNC_LOOKUP, 64'h0000_0000_0000_00a5, 4'd2, 32'h0);
    send_op(rhh_pkg::FUNC_PUT, 64'h5555_0000_0000_00a5, 4'd1, 32'h0);
    send_op(rhh_pkg::FUNC_LOOKUP, 64'h0000_0000_0000_00a5, 4'd1, 32'h0);
    send_op(rhh_pkg::FUNC_PUT, 64'h0000_0000_0000_0000, 4'd8, 32'h7fff_ffff);
    send_op(rhh_pkg::FUNC_REMOVE, 64'h0, 4'd0, 32'h0);
    send_op(rhh_pkg::FUNC_REMOVE, 64'h0, 4'd0, 32'h0);
    send_op(rhh_pkg::FUNC_REMOVE, 64'hffff_ffff_ffff_ffff, 4'd9, 32'h0);
    send_op(rhh_pkg::FUNC_LOOKUP, 64'h0, 4'd8, 32'h0);
    send_op(rhh_pkg::FUNC_CLEAR, 64'hffff_ffff_ffff_ffff, 4'd15, 32'hffff_ffff);
    send_op(rhh_pkg::FUNC_LOOKUP, 64'h0, 4'd8, 32'h0);
    stop_sending();
  endtask

  // Insert limit at zero and small, then a completely full table.
  task automatic test_limit();
    write_limit(0);
    send_op(rhh_pkg::FUNC_PUT, 64'h11, 4'd1, 32'h1);
    stop_sending();
    write_limit(3);
    for (int k = 0; k < 5; k++) send_op(rhh_pkg::FUNC_PUT, 64'(k), 4'd2, 32'(k));
    send_op(rhh_pkg::FUNC_PUT, 64'd1, 4'd2, 32'hcafe);
    send_op(rhh_pkg::FUNC_CLEAR, 64'h0, 4'd0, 32'h0);
    stop_sending();
    write_limit(256);
    for (int k = 0; k < SLOTS; k++) send_op(rhh_pkg::FUNC_PUT, 64'(k * 7), 4'd2, $urandom);
    send_op(rhh_pkg::FUNC_LOOKUP, 64'hffff, 4'd3, 32'h0);
    send_op(rhh_pkg::FUNC_PUT, 64'hffff, 4'd3, 32'h5);
    send_op(rhh_pkg::FUNC_PUT, 64'd14, 4'd2, 32'h6);
    send_op(rhh_pkg::FUNC_LOOKUP, 64'd14, 4'd2, 32'h0);
    for (int k = 0; k < 6; k++) send_op(rhh_pkg::FUNC_REMOVE, 64'(k * 7), 4'd2, 32'h0);
    send_op(rhh_pkg::FUNC_CLEAR, 64'h0, 4'd0, 32'h0);
    stop_sending();
  endtask

  // Random traffic, mostly on pool keys with garbage above the length.
  task automatic test_random(int n_items, int unsigned limit);
    int p;
    logic [1:0] func;
    logic [63:0] key;
    logic [3:0] len;
    write_limit(limit);
    for (int k = 0; k < n_items; k++) begin
      p = $urandom_range(POOL_SIZE - 1);
      key = {$urandom, $urandom};
      if ($urandom_range(99) < 80) begin
        len = pool_len[p];
        key = (len >= 8) ? pool_key[p] : ((key << (8 * len)) | pool_key[p]);
      end else begin
        len = 4'($urandom_range(15));
      end
      case ($urandom_range(99)) inside
        [0:39]:  func = rhh_pkg::FUNC_PUT;
        [40:69]: func = rhh_pkg::FUNC_LOOKUP;
        [70:97]: func = rhh_pkg::FUNC_REMOVE;
        default: func = rhh_pkg::FUNC_CLEAR;
      endcase
      send_op(func, key, len, $urandom);
    end
    stop_sending();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    errors = 0;
    idle_cycles = 0;
    sh_count = 0;
    sh_limit = rhh_pkg::MAX_ENTRIES_RST;
    send_idle_pct = 27;
    recv_idle_pct = 67;
    for (int s = 0; s < SLOTS; s++) sh_used[s] = 1'b0;
    for (int s = 0; s < POOL_SIZE; s++) begin
      pool_len[s] = 4'($urandom_range(8));
      pool_key[s] = {$urandom, $urandom} & (pool_len[s] == 0 ? 64'd0 :
                    {64{1'b1}} >> (64 - 8 * pool_len[s]));
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_limit();
    test_random(450, 40);
    send_idle_pct = 67;
    recv_idle_pct = 27;
    test_random(450, 192);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(500, 256);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
